@@ rtl/core/a85_pkg.sv @@
// ----------------------------------------------------------------------------
// a85_pkg
// Shared types and constants of the ASCII85 stream encoder.
// ----------------------------------------------------------------------------
package a85_pkg;

	localparam logic [7:0] CHAR_OFFSET  = 8'h21;
	localparam logic [7:0] CHAR_ZERO    = 8'h7A;
	localparam logic [7:0] CHAR_TILDE   = 8'h7E;
	localparam logic [7:0] CHAR_GT      = 8'h3E;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	localparam int unsigned DIGITS = 5;
	localparam int unsigned CHARS  = 8;

	// x / 85 == (x * DIV85_MAGIC) >> DIV85_SHIFT for any 32-bit x
	localparam logic [31:0] DIV85_MAGIC = 32'hC0C0C0C1;
	localparam int unsigned DIV85_SHIFT = 38;

	typedef logic [6:0] digit_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
		logic        zero;
	} grp_t;

	typedef struct packed {
		digit_t [DIGITS-1:0] dig;
		logic                last;
		logic                zero;
	} dig_t;

endpackage

@@ rtl/core/ascii85_stream_encoder_core.sv @@
// ----------------------------------------------------------------------------
// ascii85_stream_encoder_core
// ASCII85 encoder for a byte stream; the last byte closes the final group,
// which is padded and followed by "~>" and a newline.
//
//   channel  dir  tdata              tlast
//   s_*      in   [7:0] data_byte    last_byte
//   m_*      out  [7:0] out_char     last_char
//
// A group of four bytes is split in the divide-by-85 unit, one digit per
// cycle, and then handed on; a closing group is bound by its eight output
// characters. The gather, convert and emit stages overlap; a closed group
// waiting for the converter holds the input, and backpressure on m_* stalls
// the stages in turn. Reset clears all group and character counts.
// ----------------------------------------------------------------------------
module ascii85_stream_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast    // last_char
);

	a85_pkg::grp_t grp;
	logic          grp_vld;
	logic          grp_take;
	a85_pkg::dig_t dig;
	logic          dig_vld;
	logic          dig_take;

	a85_gather u_gather (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.grp      (grp),
		.grp_vld  (grp_vld),
		.grp_take (grp_take)
	);

	a85_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp      (grp),
		.grp_vld  (grp_vld),
		.grp_take (grp_take),
		.dig      (dig),
		.dig_vld  (dig_vld),
		.dig_take (dig_take)
	);

	a85_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.dig      (dig),
		.dig_vld  (dig_vld),
		.dig_take (dig_take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/core/a85_gather.sv @@
// ----------------------------------------------------------------------------
// a85_gather
// Collects input bytes into big-endian groups of four and hands each closed
// group, zero-padded when closed early by the last byte, to the converter.
// ----------------------------------------------------------------------------
module a85_gather (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] data_byte
	input  logic          s_tlast,   // last_byte
	output a85_pkg::grp_t grp,
	output logic          grp_vld,
	input  logic          grp_take
);

	logic [2:0][7:0] byte_q;
	logic [1:0]      fill_q;
	logic            grp_vld_q;
	a85_pkg::grp_t   grp_q;
	logic            beat;
	logic            close;
	logic [3:0][7:0] g;

	assign s_tready = !grp_vld_q || grp_take;
	assign beat     = s_tvalid && s_tready;
	assign close    = s_tlast || (fill_q == 2'd3);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (i < int'(fill_q)) begin
				g[i] = byte_q[i];
			end else if (i == int'(fill_q)) begin
				g[i] = s_tdata;
			end else begin
				g[i] = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 2'd0;
			grp_vld_q <= 1'b0;
		end else begin
			if (grp_take) begin
				grp_vld_q <= 1'b0;
			end
			if (beat) begin
				if (close) begin
					fill_q    <= 2'd0;
					grp_vld_q <= 1'b1;
				end else begin
					fill_q <= fill_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			if (close) begin
				grp_q.word <= {g[0], g[1], g[2], g[3]};
				grp_q.last <= s_tlast;
				grp_q.zero <= !s_tlast && ({g[0], g[1], g[2], g[3]} == 32'd0);
			end else begin
				byte_q[fill_q] <= s_tdata;
			end
		end
	end

	assign grp     = grp_q;
	assign grp_vld = grp_vld_q;

endmodule

@@ rtl/core/a85_conv.sv @@
// ----------------------------------------------------------------------------
// a85_conv
// Splits a 32-bit group into five base-85 digits, one division by 85 per
// cycle, least significant digit first.
// ----------------------------------------------------------------------------
module a85_conv (
	input  logic          clk,
	input  logic          arst_n,
	input  a85_pkg::grp_t grp,
	input  logic          grp_vld,
	output logic          grp_take,
	output a85_pkg::dig_t dig,
	output logic          dig_vld,
	input  logic          dig_take
);

	logic                                  busy_q;
	logic                                  done_q;
	logic [2:0]                            cnt_q;
	logic [31:0]                           x_q;
	a85_pkg::digit_t [a85_pkg::DIGITS-1:0] dig_q;
	logic                                  last_q;
	logic                                  zero_q;
	logic [63:0]                           prod;
	logic [31:0]                           quo;
	logic [31:0]                           rem;

	assign grp_take = grp_vld && !busy_q && (!done_q || dig_take);

	assign prod = {32'd0, x_q} * {32'd0, a85_pkg::DIV85_MAGIC};
	assign quo  = {6'd0, prod[63:a85_pkg::DIV85_SHIFT]};
	assign rem  = x_q - ((quo << 6) + (quo << 4) + (quo << 2) + quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			if (dig_take) begin
				done_q <= 1'b0;
			end
			if (grp_take) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'(a85_pkg::DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_take) begin
			x_q    <= grp.word;
			last_q <= grp.last;
			zero_q <= grp.zero;
		end else if (busy_q) begin
			x_q      <= quo;
			dig_q[0] <= rem[6:0];
			for (int i = 1; i < int'(a85_pkg::DIGITS); i++) begin
				dig_q[i] <= dig_q[i-1];
			end
		end
	end

	assign dig.dig  = dig_q;
	assign dig.last = last_q;
	assign dig.zero = zero_q;
	assign dig_vld  = done_q;

endmodule

@@ rtl/core/a85_emit.sv @@
// ----------------------------------------------------------------------------
// a85_emit
// Turns a converted group into its characters and shifts them out one per
// beat, marking the final character of the group.
// ----------------------------------------------------------------------------
module a85_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  a85_pkg::dig_t dig,
	input  logic          dig_vld,
	output logic          dig_take,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // [7:0] out_char
	output logic          m_tlast    // last_char
);

	logic [a85_pkg::CHARS-1:0][7:0] ch_q;
	logic [3:0]                     n_q;
	logic                           beat;

	assign m_tvalid = (n_q != 4'd0);
	assign m_tlast  = (n_q == 4'd1);
	assign m_tdata  = ch_q[0];
	assign beat     = m_tvalid && m_tready;
	assign dig_take = dig_vld && (!m_tvalid || (beat && m_tlast));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 4'd0;
		end else if (dig_take) begin
			if (dig.zero) begin
				n_q <= 4'd1;
			end else if (dig.last) begin
				n_q <= 4'(a85_pkg::CHARS);
			end else begin
				n_q <= 4'(a85_pkg::DIGITS);
			end
		end else if (beat) begin
			n_q <= n_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (dig_take) begin
			if (dig.zero) begin
				ch_q[0] <= a85_pkg::CHAR_ZERO;
			end else begin
				for (int i = 0; i < int'(a85_pkg::DIGITS); i++) begin
					ch_q[i] <= {1'b0, dig.dig[i]} + a85_pkg::CHAR_OFFSET;
				end
				ch_q[5] <= a85_pkg::CHAR_TILDE;
				ch_q[6] <= a85_pkg::CHAR_GT;
				ch_q[7] <= a85_pkg::CHAR_NEWLINE;
			end
		end else if (beat) begin
			for (int i = 0; i < int'(a85_pkg::CHARS) - 1; i++) begin
				ch_q[i] <= ch_q[i+1];
			end
		end
	end

endmodule
